// ----- rtl/core/yee_pkg.sv -----
package yee_pkg;

  localparam int MaxCells     = 16;
  localparam int FieldBits    = 32;
  localparam int CoefFracBits = 20;
  localparam int Side         = MaxCells + 1;
  localparam int Nodes        = Side * Side * Side;
  localparam int AddrBits     = $clog2(Nodes);
  localparam int PosBits      = 5;
  localparam int CellBits     = 5;
  localparam int CoefBits     = 32;
  localparam int SampleBits   = 32;
  localparam int CompBits     = 3;
  localparam int OpBits       = 2;
  localparam int CfgIdxBits   = 3;
  localparam int CfgDataBits  = 32;
  // curl difference of four samples
  localparam int DiffBits     = FieldBits + 3;
  localparam int ProdBits     = DiffBits + CoefBits;

  typedef logic signed [FieldBits-1:0] field_t;
  typedef logic [AddrBits-1:0]         addr_t;
  typedef logic [PosBits-1:0]          pos_t;

  localparam logic [OpBits-1:0] OP_WRITE = 2'd0;
  localparam logic [OpBits-1:0] OP_READ  = 2'd1;
  localparam logic [OpBits-1:0] OP_SWH   = 2'd2;
  localparam logic [OpBits-1:0] OP_SWE   = 2'd3;

  localparam logic [CfgIdxBits-1:0] REG_COEF_M = 3'd0;
  localparam logic [CfgIdxBits-1:0] REG_COEF_E = 3'd1;
  localparam logic [CfgIdxBits-1:0] REG_CELLS_X = 3'd2;
  localparam logic [CfgIdxBits-1:0] REG_CELLS_Y = 3'd3;
  localparam logic [CfgIdxBits-1:0] REG_CELLS_Z = 3'd4;

  // memory port request into one field store
  typedef struct packed {
    logic   we;
    addr_t  waddr;
    field_t wdata;
    addr_t  raddr;
  } mem_req_t;

  function automatic addr_t node_addr(input pos_t i, input pos_t j, input pos_t k);
    logic [AddrBits+1:0] a;
    a = ((AddrBits+2)'(i) * (AddrBits+2)'(Side) + (AddrBits+2)'(j)) * (AddrBits+2)'(Side)
        + (AddrBits+2)'(k);
    return a[AddrBits-1:0];
  endfunction

  function automatic logic [CellBits-1:0] clamp_cells(input logic [CfgDataBits-1:0] v);
    logic [CellBits-1:0] c;
    c = v[CellBits-1:0];
    if (c == '0) return CellBits'(1);
    if (c > CellBits'(MaxCells)) return CellBits'(MaxCells);
    return c;
  endfunction

endpackage

// ----- rtl/core/yee_stream_if.sv -----
interface yee_in_if;
  import yee_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [OpBits-1:0]           opcode;
  logic [CompBits-1:0]         component;
  logic [PosBits-1:0]          pos_x;
  logic [PosBits-1:0]          pos_y;
  logic [PosBits-1:0]          pos_z;
  logic signed [SampleBits-1:0] sample_in;
  modport source (output valid, opcode, component, pos_x, pos_y, pos_z, sample_in,
                  input ready);
  modport sink (input valid, opcode, component, pos_x, pos_y, pos_z, sample_in,
                output ready);
endinterface

interface yee_out_if;
  import yee_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample_out;
  logic                         status;
  modport source (output valid, sample_out, status, input ready);
  modport sink (input valid, sample_out, status, output ready);
endinterface

interface yee_cfg_if;
  import yee_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CfgIdxBits-1:0]  index;
  logic [CfgDataBits-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/yee_fdtd_field_update.sv -----
// Read/write: the request is registered, the store read is registered, then the result register loads.
// A sweep reads four samples per node over the stores' single read port and shares one multiplier.
// One request at a time; the next is taken while a result waits, then holds at its end.
// After reset a clearing pass over all 4913 nodes zeroes all six stores; no request taken.
module yee_fdtd_field_update (
  input  logic clk,
  input  logic rst_n,
  yee_in_if.sink    in_ch,
  yee_out_if.source out_ch,
  yee_cfg_if.sink   cfg_ch
);
  import yee_pkg::*;

  yee_field_update u_core (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );
endmodule

// ----- rtl/core/yee_field_ram.sv -----
// One field store: one write, one registered read per cycle
module yee_field_ram (
  input  logic              clk,
  input  yee_pkg::mem_req_t req,
  output yee_pkg::field_t   rdata
);
  import yee_pkg::*;

  field_t mem [Nodes];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule

// ----- rtl/core/yee_scale_unit.sv -----
// Shared multiply, round, saturate unit. Two register stages.
// out = sat(old +/- round(coef * diff)), registered in the product stage and then the result stage.
module yee_scale_unit (
  input  logic                                  clk,
  input  logic [yee_pkg::CoefBits-1:0]          coef,
  input  logic signed [yee_pkg::DiffBits-1:0]   diff,
  input  yee_pkg::field_t                       old_val,
  input  logic                                  subtract,
  output yee_pkg::field_t                       result
);
  import yee_pkg::*;

  localparam logic [ProdBits-1:0] RoundHalf = ProdBits'(1) << (CoefFracBits - 1);
  localparam int SumBits = ProdBits - CoefFracBits + 2;
  localparam logic signed [SumBits-1:0] FMax = SumBits'((64'sd1 <<< (FieldBits-1)) - 1);
  localparam logic signed [SumBits-1:0] FMin = -FMax - SumBits'(1);

  logic [DiffBits-1:0]  mag;
  logic                 neg;
  logic [ProdBits-1:0]  prod_r;
  logic                 neg_r;
  logic                 sub_r;
  field_t               old_r;
  logic [ProdBits-1:0]  rounded;
  logic signed [SumBits-1:0] term;
  logic signed [SumBits-1:0] sum;

  assign neg = diff[DiffBits-1];
  assign mag = neg ? DiffBits'(-diff) : DiffBits'(diff);

  // stage 1: magnitude product (35 x 32)
  always_ff @(posedge clk) begin
    prod_r <= ProdBits'(mag) * ProdBits'(coef);
    neg_r  <= neg;
    sub_r  <= subtract;
    old_r  <= old_val;
  end

  // stage 2: round half away, sign, accumulate, saturate
  always_comb begin
    rounded = (prod_r + RoundHalf) >> CoefFracBits;
    term = (neg_r ^ sub_r) ? -$signed(SumBits'(rounded)) : $signed(SumBits'(rounded));
    sum  = SumBits'(old_r) + term;
  end

  always_ff @(posedge clk) begin
    if (sum > FMax) begin
      result <= FieldBits'(FMax);
    end else if (sum < FMin) begin
      result <= FieldBits'(FMin);
    end else begin
      result <= FieldBits'(sum);
    end
  end
endmodule

// ----- rtl/core/yee_field_update.sv -----
// Sweep sequencer and six field stores.
// Per node of a sweep: four reads for the curl, multiply, write.
module yee_field_update (
  input  logic clk,
  input  logic rst_n,
  yee_in_if.sink   in_ch,
  yee_out_if.source out_ch,
  yee_cfg_if.sink  cfg_ch
);
  import yee_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RW, S_RD_WAIT, S_NODE, S_RD0, S_RD1, S_RD2, S_RD3,
    S_CALC, S_WAIT, S_WR, S_DONE
  } state_t;

  state_t state_r;
  logic [CoefBits-1:0] coef_m_r, coef_e_r;
  logic [CellBits-1:0] nx_r, ny_r, nz_r;
  logic [OpBits-1:0]   op_r;
  logic [CompBits-1:0] comp_r;
  pos_t   px_r, py_r, pz_r;
  field_t smp_r;
  logic [1:0] pass_r;      // which component of the sweep
  pos_t  i_r, j_r, k_r;
  addr_t clr_r;
  field_t a_r, b_r, c_r, d_r, cur_r;
  logic [SampleBits-1:0] sout_r;
  logic  stat_r;
  logic  ovalid_r;

  mem_req_t req [6];
  field_t   rd [6];

  for (genvar g = 0; g < 6; g++) begin : g_mem
    yee_field_ram u_ram (.clk(clk), .req(req[g]), .rdata(rd[g]));
  end

  // component written by a sweep pass, and the two it reads
  logic [2:0] dst_c, src1_c, src2_c;
  logic       is_e;
  always_comb begin
    is_e = (op_r == OP_SWE);
    unique case (pass_r)
      2'd0: begin dst_c = is_e ? 3'd0 : 3'd3; src1_c = is_e ? 3'd5 : 3'd2;
                  src2_c = is_e ? 3'd4 : 3'd1; end
      2'd1: begin dst_c = is_e ? 3'd1 : 3'd4; src1_c = is_e ? 3'd3 : 3'd0;
                  src2_c = is_e ? 3'd5 : 3'd2; end
      default: begin dst_c = is_e ? 3'd2 : 3'd5; src1_c = is_e ? 3'd4 : 3'd1;
                  src2_c = is_e ? 3'd3 : 3'd0; end
    endcase
  end

  // loop bounds per pass: lo (0/1) and hi (exclusive)
  logic [CellBits:0] hi_i, hi_j, hi_k;
  logic lo_i, lo_j, lo_k;
  always_comb begin
    hi_i = {1'b0, nx_r}; hi_j = {1'b0, ny_r}; hi_k = {1'b0, nz_r};
    lo_i = 1'b0; lo_j = 1'b0; lo_k = 1'b0;
    if (!is_e) begin
      unique case (pass_r)
        2'd0: hi_i = hi_i + 1'b1;
        2'd1: hi_j = hi_j + 1'b1;
        default: hi_k = hi_k + 1'b1;
      endcase
    end else begin
      unique case (pass_r)
        2'd0: begin lo_j = 1'b1; lo_k = 1'b1; end
        2'd1: begin lo_i = 1'b1; lo_k = 1'b1; end
        default: begin lo_i = 1'b1; lo_j = 1'b1; end
      endcase
    end
  end

  // an E pass on a single-cell axis has no interior nodes
  logic pass_empty;
  assign pass_empty = (hi_i <= (CellBits+1)'(lo_i)) || (hi_j <= (CellBits+1)'(lo_j)) ||
                      (hi_k <= (CellBits+1)'(lo_k));

  // neighbor offsets: H uses +1, E uses -1
  pos_t i_n, j_n, k_n;
  pos_t ia, ja, ka, ib, jb, kb;
  always_comb begin
    i_n = is_e ? i_r - 1'b1 : i_r + 1'b1;
    j_n = is_e ? j_r - 1'b1 : j_r + 1'b1;
    k_n = is_e ? k_r - 1'b1 : k_r + 1'b1;
    // a: neighbor of src1, b: neighbor of src2
    unique case (pass_r)
      2'd0: begin ia = i_r; ja = j_n; ka = k_r; ib = i_r; jb = j_r; kb = k_n; end
      2'd1: begin ia = i_r; ja = j_r; ka = k_n; ib = i_n; jb = j_r; kb = k_r; end
      default: begin ia = i_n; ja = j_r; ka = k_r; ib = i_r; jb = j_n; kb = k_r; end
    endcase
  end

  addr_t here_a;
  assign here_a = node_addr(i_r, j_r, k_r);

  // difference: H: (a1-a0)-(b1-b0); E: (a0-a1)-(b0-b1), with a0,b0 at the node
  logic signed [DiffBits-1:0] diff;
  always_comb begin
    if (is_e) begin
      diff = (DiffBits'(c_r) - DiffBits'(a_r)) - (DiffBits'(d_r) - DiffBits'(b_r));
    end else begin
      diff = (DiffBits'(a_r) - DiffBits'(c_r)) - (DiffBits'(b_r) - DiffBits'(d_r));
    end
  end

  field_t upd;
  yee_scale_unit u_scale (
    .clk(clk), .coef(is_e ? coef_e_r : coef_m_r), .diff(diff), .old_val(cur_r),
    .subtract(!is_e), .result(upd)
  );

  logic pos_bad;
  assign pos_bad = (comp_r > 3'd5) || (px_r > nx_r) || (py_r > ny_r) || (pz_r > nz_r);
  addr_t pos_a;
  assign pos_a = node_addr(px_r, py_r, pz_r);

  // memory requests; a read request keeps its address while the result waits
  always_comb begin
    for (int m = 0; m < 6; m++) begin
      req[m].we    = 1'b0;
      req[m].waddr = here_a;
      req[m].wdata = upd;
      req[m].raddr = here_a;
    end
    unique case (state_r)
      S_CLEAR: begin
        for (int m = 0; m < 6; m++) begin
          req[m].we = 1'b1; req[m].waddr = clr_r; req[m].wdata = '0;
        end
      end
      S_RW, S_RD_WAIT: begin
        for (int m = 0; m < 6; m++) begin
          req[m].raddr = pos_a;
          req[m].waddr = pos_a;
          req[m].wdata = smp_r;
          req[m].we = (state_r == S_RW) && (op_r == OP_WRITE) && !pos_bad &&
                      (comp_r == 3'(m));
        end
      end
      S_RD0: req[src1_c].raddr = node_addr(ia, ja, ka);
      S_RD1: req[src2_c].raddr = node_addr(ib, jb, kb);
      S_WR: req[dst_c].we = 1'b1;
      default: ;
    endcase
  end

  logic fin_k, fin_j, fin_i;
  assign fin_k = ({1'b0, k_r} + 1'b1) >= hi_k;
  assign fin_j = ({1'b0, j_r} + 1'b1) >= hi_j;
  assign fin_i = ({1'b0, i_r} + 1'b1) >= hi_i;

  // result register loads once the previous result has left
  logic res_load;
  assign res_load = ((state_r == S_RD_WAIT) || (state_r == S_DONE)) &&
                    (!ovalid_r || out_ch.ready);

  assign in_ch.ready   = (state_r == S_IDLE);
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = ovalid_r;
  assign out_ch.sample_out = sout_r;
  assign out_ch.status = stat_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; ovalid_r <= 1'b0;
      coef_m_r <= '0; coef_e_r <= '0;
      nx_r <= CellBits'(MaxCells); ny_r <= CellBits'(MaxCells); nz_r <= CellBits'(MaxCells);
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_COEF_M:  coef_m_r <= cfg_ch.data;
          REG_COEF_E:  coef_e_r <= cfg_ch.data;
          REG_CELLS_X: nx_r <= clamp_cells(cfg_ch.data);
          REG_CELLS_Y: ny_r <= clamp_cells(cfg_ch.data);
          REG_CELLS_Z: nz_r <= clamp_cells(cfg_ch.data);
          default: ;
        endcase
      end
      if (res_load) begin
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == addr_t'(Nodes - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r <= in_ch.opcode; comp_r <= in_ch.component;
            px_r <= in_ch.pos_x; py_r <= in_ch.pos_y; pz_r <= in_ch.pos_z;
            smp_r <= in_ch.sample_in;
            pass_r <= 2'd0;
            state_r <= (in_ch.opcode == OP_SWH || in_ch.opcode == OP_SWE) ? S_NODE : S_RW;
          end
        end
        S_RW: state_r <= S_RD_WAIT;
        S_RD_WAIT: begin
          if (res_load) begin
            stat_r <= pos_bad;
            sout_r <= (op_r == OP_READ && !pos_bad) ? rd[comp_r] : '0;
            state_r <= S_IDLE;
          end
        end
        S_NODE: begin
          if (pass_empty) begin
            if (pass_r != 2'd2) begin
              pass_r <= pass_r + 1'b1;
            end else begin
              state_r <= S_DONE;
            end
          end else begin
            i_r <= pos_t'(lo_i); j_r <= pos_t'(lo_j); k_r <= pos_t'(lo_k);
            state_r <= S_RD0;
          end
        end
        S_RD0: state_r <= S_RD1;   // neighbor of first source
        S_RD1: begin               // neighbor of second source
          a_r <= rd[src1_c];
          state_r <= S_RD2;
        end
        S_RD2: begin               // node itself, all stores
          b_r <= rd[src2_c];
          state_r <= S_RD3;
        end
        S_RD3: begin
          c_r <= rd[src1_c]; d_r <= rd[src2_c]; cur_r <= rd[dst_c];
          state_r <= S_CALC;
        end
        S_CALC: state_r <= S_WAIT;
        S_WAIT: state_r <= S_WR;
        S_WR: begin
          if (!fin_k) begin
            k_r <= k_r + 1'b1; state_r <= S_RD0;
          end else if (!fin_j) begin
            k_r <= pos_t'(lo_k); j_r <= j_r + 1'b1; state_r <= S_RD0;
          end else if (!fin_i) begin
            k_r <= pos_t'(lo_k); j_r <= pos_t'(lo_j); i_r <= i_r + 1'b1; state_r <= S_RD0;
          end else if (pass_r != 2'd2) begin
            pass_r <= pass_r + 1'b1; state_r <= S_NODE;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_load) begin
            sout_r <= '0; stat_r <= 1'b0; state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // cell counts are clamped, never zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (nx_r != '0 && ny_r != '0 && nz_r != '0))
    else $error("cell count zero");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !ovalid_r)
    else $error("result during clear");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> $past(state_r, 1) == S_WAIT)
    else $error("write without product");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_ch.ready) |=> (ovalid_r && $stable(sout_r) && $stable(stat_r)))
    else $error("result changed while waiting");
endmodule
